FILE: hw/rtl/register_machine_step_assert.svh
// assertion macros for the register machine
`ifndef REGISTER_MACHINE_STEP_ASSERT_SVH
`define REGISTER_MACHINE_STEP_ASSERT_SVH
`define RMS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define RMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: hw/rtl/rms_pkg.sv
// ----------------------------------------------------------------------------
// rms_pkg
// types and constants of the register machine
// ----------------------------------------------------------------------------
package rms_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned PcW   = 11;

  typedef enum logic [2:0] {
    KIND_LOAD  = 3'd0,
    KIND_READ  = 3'd1,
    KIND_RREG  = 3'd2,
    KIND_RST   = 3'd3,
    KIND_STEP  = 3'd4,
    KIND_NONE5 = 3'd5,
    KIND_NONE6 = 3'd6,
    KIND_NONE7 = 3'd7
  } kind_e;

  localparam logic [4:0] OP_A = 5'd0, OP_AR = 5'd1, OP_M = 5'd2, OP_MR = 5'd3;
  localparam logic [4:0] OP_S = 5'd4, OP_SR = 5'd5, OP_D = 5'd6, OP_DR = 5'd7;
  localparam logic [4:0] OP_L = 5'd8, OP_LR = 5'd9, OP_LA = 5'd10, OP_J = 5'd11;
  localparam logic [4:0] OP_JN = 5'd12, OP_JZ = 5'd13, OP_JP = 5'd14;
  localparam logic [4:0] OP_ST = 5'd15, OP_C = 5'd16, OP_CR = 5'd17;

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_END   = 1'b1;

  typedef struct packed {
    logic [2:0]        kind;
    logic [9:0]        address;
    logic signed [31:0] data;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic signed [31:0] condition;
    logic [10:0]        counter;
    logic               halted;
    logic               fault;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MEMRD, ST_FETCH, ST_DECODE, ST_ADDR, ST_OPRD, ST_OPWAIT,
    ST_EXEC, ST_DIV, ST_FINISH, ST_OUT
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic       take_in;
    logic       mem_rd_in;
    logic       fetch;
    logic [1:0] fetch_idx;
    logic       decode;
    logic       addr_calc;
    logic       op_rd;
    logic       exec;
    logic       div_start;
    logic       div_step;
    logic       finish;
    logic       out_load;
  } cmd_t;

  // status back to the controller
  typedef struct packed {
    logic is_step;
    logic run_ok;
    logic memform;
    logic early_done;
    logic div_op;
    logic div_done;
  } stat_t;

endpackage

FILE: hw/rtl/rms_ctrl.sv
// ----------------------------------------------------------------------------
// rms_ctrl
// sequencer for one item: fetch, operand read, execute, divide, result
// ----------------------------------------------------------------------------
`include "register_machine_step_assert.svh"
module rms_ctrl
  import rms_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic [1:0] idx_q, idx_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_MEMRD;
      ST_MEMRD:  begin
        idx_d = '0;
        if (stat_i.is_step && stat_i.run_ok) state_d = ST_FETCH;
        else state_d = ST_FINISH;
      end
      ST_FETCH:  begin
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) state_d = ST_DECODE;
      end
      ST_DECODE: state_d = ST_ADDR;
      ST_ADDR:   state_d = stat_i.early_done ? ST_FINISH : ST_OPRD;
      ST_OPRD:   state_d = ST_OPWAIT;
      ST_OPWAIT: state_d = ST_EXEC;
      ST_EXEC:   state_d = stat_i.div_op ? ST_DIV : ST_FINISH;
      ST_DIV:    if (stat_i.div_done) state_d = ST_FINISH;
      ST_FINISH: state_d = ST_OUT;
      ST_OUT:    if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.fetch_idx = idx_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE:   begin
        in_ready_o    = 1'b1;
        cmd_o.take_in = in_valid_i;
      end
      ST_MEMRD:  cmd_o.mem_rd_in = 1'b1;
      ST_FETCH:  cmd_o.fetch = 1'b1;
      ST_DECODE: cmd_o.decode = 1'b1;
      ST_ADDR:   cmd_o.addr_calc = 1'b1;
      ST_OPRD:   cmd_o.op_rd = 1'b1;
      ST_OPWAIT: ;
      ST_EXEC:   begin
        cmd_o.exec      = 1'b1;
        cmd_o.div_start = stat_i.div_op;
      end
      ST_DIV:    cmd_o.div_step = 1'b1;
      ST_FINISH: cmd_o.finish = 1'b1;
      ST_OUT:    cmd_o.out_load = !out_valid_q || out_ready_i;
      default:   ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  `RMS_ASSERT(a_ready_idle, clk_i, rst_ni, !in_ready_o || state_q == ST_IDLE)
  `RMS_ASSERT_NEXT(a_take_mem, clk_i, rst_ni, in_valid_i && in_ready_o,
                   state_q == ST_MEMRD)
  `RMS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && !out_ready_i,
                   out_valid_q)

endmodule

FILE: hw/rtl/rms_dp.sv
// ----------------------------------------------------------------------------
// rms_dp
// datapath: word memory, register file, operand logic and serial divider
// ----------------------------------------------------------------------------
module rms_dp
  import rms_pkg::*;
#(
  parameter int unsigned MemWords = 1024,
  parameter int unsigned NumRegs  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_item_t    item_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  output out_item_t   out_o
);

  localparam int unsigned AW = (MemWords > 1) ? $clog2(MemWords) : 1;
  localparam int unsigned RW = (NumRegs > 1) ? $clog2(NumRegs) : 1;
  localparam logic [PcW:0] MemLimit = (PcW+1)'(MemWords);

  logic [DataW-1:0] mem [MemWords];
  logic [DataW-1:0] regs_q [NumRegs];

  logic [9:0]  start_q;
  logic [10:0] end_q;
  logic [PcW-1:0] pc_q;
  logic [DataW-1:0] cond_q;

  in_item_t item_q;
  logic [DataW-1:0] rdata_q;
  logic [DataW-1:0] ins_q [4];
  logic [DataW-1:0] x_q, y_q, res_q;
  logic [AW-1:0] maddr_q;
  logic fault_q, flt_out_q;
  logic [DataW-1:0] rv_q;
  out_item_t out_q;
  logic memy_q;
  logic wb_q;

  // memory port
  logic mem_re, mem_we;
  logic [AW-1:0] mem_ra, mem_wa;
  logic [DataW-1:0] mem_wd;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_q <= mem[mem_ra];
  end

  // decode
  logic [4:0] op;
  logic op_known, opok, memform, a1ok, a2ok, a3ok;
  logic [DataW-1:0] a1, a2, a3;
  assign a1 = ins_q[1];
  assign a2 = ins_q[2];
  assign a3 = ins_q[3];
  assign op = ins_q[0][4:0];
  assign op_known = (ins_q[0][DataW-1:5] == '0);
  assign opok = op_known && (op <= OP_LR || op == OP_ST || op == OP_C || op == OP_CR);
  assign memform = ((op <= OP_L) && !op[0]) || op == OP_ST || op == OP_C;
  assign a1ok = a1 < DataW'(NumRegs);
  assign a2ok = a2 < DataW'(NumRegs);
  assign a3ok = a3 < DataW'(NumRegs);

  logic [DataW-1:0] r1, r2, r3;
  assign r1 = regs_q[a1[RW-1:0]];
  assign r2 = regs_q[a2[RW-1:0]];
  assign r3 = regs_q[a3[RW-1:0]];

  // memory operand address, truncated quarter of r3
  logic signed [DataW-1:0] q4;
  logic signed [DataW:0] msum;
  assign q4 = $signed(r3) >>> 2;
  always_comb begin
    msum = $signed({a2[DataW-1], a2}) + $signed({q4[DataW-1], q4});
    if (r3[DataW-1] && r3[1:0] != 2'b00) msum = msum + (DataW+1)'(1);
  end

  logic div_q;
  logic jump_taken;
  always_comb begin
    unique case (op)
      OP_JN:   jump_taken = cond_q[DataW-1];
      OP_JZ:   jump_taken = cond_q == '0;
      OP_JP:   jump_taken = !cond_q[DataW-1] && cond_q != '0;
      default: jump_taken = 1'b1;
    endcase
  end

  // register number and address faults of the fetched instruction
  logic addr_flt;
  always_comb begin
    addr_flt = 1'b0;
    if (!opok) begin
      if (op_known && op == OP_LA) addr_flt = !a1ok;
      else if (op_known && op >= OP_J && op <= OP_JP)
        addr_flt = jump_taken && (a1 >= DataW'(MemWords));
    end else if (!a1ok) begin
      addr_flt = 1'b1;
    end else if (memform) begin
      addr_flt = !a3ok || msum[DataW] || msum >= (DataW+1)'(MemWords);
    end else begin
      addr_flt = !a2ok;
    end
  end

  // serial divider
  logic [DataW-1:0] dq_q, drem_q, dden_q;
  logic [5:0] dcnt_q;
  logic dneg_q;
  logic [DataW:0] dtrial;
  assign dtrial = {drem_q, dq_q[DataW-1]} - {1'b0, dden_q};

  // value written back at the end of an arithmetic or load instruction
  logic [DataW-1:0] wb_val;
  assign wb_val = div_q ? (dneg_q ? (~dq_q + DataW'(1)) : dq_q) : res_q;

  logic [PcW-1:0] pc_next;
  assign pc_next = pc_q + PcW'(4);
  logic [PcW:0] pc_last;
  assign pc_last = {1'b0, pc_q} + (PcW+1)'(3);

  always_comb begin
    mem_re = 1'b0;
    mem_ra = item_q.address[AW-1:0];
    mem_we = 1'b0;
    mem_wa = item_q.address[AW-1:0];
    mem_wd = item_q.data;
    if (cmd_i.mem_rd_in) begin
      mem_re = (item_q.kind == KIND_READ);
      mem_we = (item_q.kind == KIND_LOAD) && ({1'b0, item_q.address} < MemLimit);
    end
    if (cmd_i.fetch) begin
      mem_re = 1'b1;
      mem_ra = pc_q[AW-1:0] + AW'(cmd_i.fetch_idx);
    end
    if (cmd_i.op_rd) begin
      mem_re = 1'b1;
      mem_ra = maddr_q;
    end
    if (cmd_i.exec && opok && op == OP_ST && !fault_q) begin
      mem_we = 1'b1;
      mem_wa = maddr_q;
      mem_wd = r1;
    end
  end

  logic [1:0] fidx_q;
  logic fetch_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) regs_q[i] <= '0;
      start_q   <= '0;
      end_q     <= '0;
      pc_q      <= '0;
      cond_q    <= '0;
      fetch_v_q <= 1'b0;
      dcnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_START) start_q <= cfg_data_i[9:0];
        else end_q <= cfg_data_i;
      end
      fetch_v_q <= cmd_i.fetch;
      if (cmd_i.mem_rd_in && item_q.kind == KIND_RST) pc_q <= PcW'(start_q);
      if (cmd_i.decode) pc_q <= pc_next;
      if (cmd_i.div_start) dcnt_q <= 6'(DataW);
      else if (cmd_i.div_step && dcnt_q != '0) dcnt_q <= dcnt_q - 6'd1;
      if (cmd_i.exec && !fault_q) begin
        if (op_known && op >= OP_J && op <= OP_JP) begin
          if (jump_taken) begin
            pc_q   <= a1[PcW-1:0];
            cond_q <= DataW'(1);
          end else begin
            cond_q <= '0;
          end
        end else if (op_known && op == OP_LA) begin
          regs_q[a1[RW-1:0]] <= a2;
          cond_q <= a2;
        end else if (opok && op == OP_ST) begin
          cond_q <= r1;
        end
      end
      if (cmd_i.finish && wb_q && !fault_q) begin
        if (op != OP_C && op != OP_CR) regs_q[a1[RW-1:0]] <= wb_val;
        cond_q <= wb_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) item_q <= item_i;
    if (fetch_v_q) ins_q[fidx_q] <= rdata_q;
    fidx_q <= cmd_i.fetch_idx;
    if (cmd_i.mem_rd_in) begin
      fault_q <= 1'b0;
      rv_q    <= '0;
      div_q   <= 1'b0;
      wb_q    <= 1'b0;
      if (item_q.kind == KIND_STEP) fault_q <= (pc_q < end_q) && (pc_last >= MemLimit);
      if (item_q.kind == KIND_LOAD || item_q.kind == KIND_READ)
        fault_q <= {1'b0, item_q.address} >= MemLimit;
      if (item_q.kind == KIND_RREG) begin
        if ({1'b0, item_q.address} < 11'(NumRegs)) rv_q <= regs_q[item_q.address[RW-1:0]];
        else fault_q <= 1'b1;
      end
    end
    if (cmd_i.decode) begin
      // the last fetched word is still in rdata_q and is written into ins_q in this state
    end
    if (cmd_i.addr_calc) begin
      maddr_q <= msum[AW-1:0];
      fault_q <= fault_q | addr_flt;
    end
    memy_q <= cmd_i.op_rd && memform;
    if (cmd_i.op_rd) x_q <= r1;
    if (cmd_i.op_rd && !memform) y_q <= r2;
    if (memy_q) y_q <= rdata_q;
    if (cmd_i.exec) begin
      unique case (op)
        OP_A, OP_AR:                 res_q <= x_q + y_q;
        OP_M, OP_MR:                 res_q <= x_q * y_q;
        OP_S, OP_SR, OP_C, OP_CR:    res_q <= x_q - y_q;
        OP_L, OP_LR:                 res_q <= y_q;
        default:                     res_q <= '0;
      endcase
      div_q <= opok && (op == OP_D || op == OP_DR);
      wb_q  <= opok && op != OP_ST;
      if (opok && (op == OP_D || op == OP_DR) && y_q == '0) fault_q <= 1'b1;
      dq_q   <= x_q[DataW-1] ? (~x_q + DataW'(1)) : x_q;
      dden_q <= y_q[DataW-1] ? (~y_q + DataW'(1)) : y_q;
      drem_q <= '0;
      dneg_q <= x_q[DataW-1] ^ y_q[DataW-1];
    end
    if (cmd_i.div_step && dcnt_q != '0) begin
      if (!dtrial[DataW]) begin
        drem_q <= dtrial[DataW-1:0];
        dq_q   <= {dq_q[DataW-2:0], 1'b1};
      end else begin
        drem_q <= {drem_q[DataW-2:0], dq_q[DataW-1]};
        dq_q   <= {dq_q[DataW-2:0], 1'b0};
      end
    end
    if (cmd_i.finish) flt_out_q <= fault_q;
    if (cmd_i.out_load) begin
      out_q.read_value <= (item_q.kind == KIND_READ && !fault_q) ? rdata_q : rv_q;
      out_q.condition  <= cond_q;
      out_q.counter    <= pc_q;
      out_q.halted     <= pc_q >= end_q;
      out_q.fault      <= flt_out_q;
    end
  end

  always_comb begin
    stat_o.is_step    = item_q.kind == KIND_STEP;
    stat_o.run_ok     = pc_q < end_q;
    stat_o.memform    = memform;
    stat_o.early_done = fault_q | addr_flt;
    stat_o.div_op     = (op == OP_D || op == OP_DR) && op_known && y_q != '0;
    stat_o.div_done   = dcnt_q == '0;
  end

  assign out_o = out_q;

endmodule

FILE: hw/rtl/register_machine_step.sv
// item to result: load, read, restart and halted steps go straight to the result; a
// step fetches, decodes and executes, ends early on a fetch or address fault, and a
// divide also runs the serial divider; throughput: one item at a time while the
// result side keeps up; a waiting result holds the next one back
// reset: registers, counter, condition and configuration clear; word memory
// holds no reset value and needs no clearing pass
// ----------------------------------------------------------------------------
// register_machine_step
// small register machine with a shared word memory, one instruction per step
// ----------------------------------------------------------------------------
module register_machine_step
  import rms_pkg::*;
#(
  parameter int unsigned MEM_WORDS = 1024,
  parameter int unsigned NUM_REGS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);

  cmd_t  cmd;
  stat_t stat;
  out_item_t dp_out;

  rms_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  rms_dp #(.MemWords(MEM_WORDS), .NumRegs(NUM_REGS)) u_dp (
    .clk_i, .rst_ni, .item_i(in_data_i), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_i(cmd), .stat_o(stat), .out_o(dp_out)
  );

  assign out_data_o = dp_out;

endmodule
